// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// invariant
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant");

`endif

// ===== rtl/fdtp_pkg.sv =====
// ----------------------------------------------------------------------------
// fdtp_pkg
// types, codes and helpers for the device-tree structure token parser
// ----------------------------------------------------------------------------
package fdtp_pkg;

  localparam int MAX_DEPTH = 64;
  localparam int DEPTH_W   = 7;
  localparam int KIND_W    = 4;
  localparam int PHASE_W   = 3;

  // depth ceiling, clipped to what the depth field can hold
  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT =
    (MAX_DEPTH > 127) ? 7'd127 : DEPTH_W'(MAX_DEPTH);

  // parser phases
  localparam logic [PHASE_W-1:0] PH_TOKEN = 3'd0;
  localparam logic [PHASE_W-1:0] PH_NAME  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PLEN  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_POFF  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] K_BEGIN    = 4'd0;
  localparam logic [KIND_W-1:0] K_NAME     = 4'd1;
  localparam logic [KIND_W-1:0] K_ENDNODE  = 4'd2;
  localparam logic [KIND_W-1:0] K_PLEN     = 4'd3;
  localparam logic [KIND_W-1:0] K_POFF     = 4'd4;
  localparam logic [KIND_W-1:0] K_DATA     = 4'd5;
  localparam logic [KIND_W-1:0] K_NOP      = 4'd6;
  localparam logic [KIND_W-1:0] K_END      = 4'd7;
  localparam logic [KIND_W-1:0] K_BAD      = 4'd8;
  localparam logic [KIND_W-1:0] K_IGNORED  = 4'd9;
  localparam logic [KIND_W-1:0] K_DEPTHERR = 4'd10;

  // structure block tokens, big-endian value
  localparam logic [31:0] TOK_BEGIN_NODE = 32'h0000_0001;
  localparam logic [31:0] TOK_END_NODE   = 32'h0000_0002;
  localparam logic [31:0] TOK_PROP       = 32'h0000_0003;
  localparam logic [31:0] TOK_NOP        = 32'h0000_0004;
  localparam logic [31:0] TOK_END        = 32'h0000_0009;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [DEPTH_W-1:0] nest_depth;
    logic [31:0]        bytes_left;
    logic               stopped;
  } fdtp_state_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DEPTH_W-1:0] depth;
    logic [31:0]        value;
    logic               last_word;
    logic [2:0]         valid_bytes;
  } fdtp_result_t;

  localparam fdtp_state_t STATE_RESET = '{
    phase:      PH_TOKEN,
    nest_depth: '0,
    bytes_left: '0,
    stopped:    1'b0
  };

  function automatic logic [31:0] swap32(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// ===== rtl/fdtp_in_if.sv =====
// ----------------------------------------------------------------------------
// fdtp_in_if
// input channel: one structure-block word per transaction
// ----------------------------------------------------------------------------
interface fdtp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        restart;

  modport source (output valid, output word, output restart, input ready);
  modport sink (input valid, input word, input restart, output ready);
endinterface

// ===== rtl/fdtp_out_if.sv =====
// ----------------------------------------------------------------------------
// fdtp_out_if
// result channel: one classified word per transaction
// ----------------------------------------------------------------------------
interface fdtp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [6:0]  depth;
  logic [31:0] value;
  logic        last_word;
  logic [2:0]  valid_bytes;

  modport source (output valid, output kind, output depth, output value,
                  output last_word, output valid_bytes, input ready);
  modport sink (input valid, input kind, input depth, input value,
                input last_word, input valid_bytes, output ready);
endinterface

// ===== rtl/fdtp_classify.sv =====
// ----------------------------------------------------------------------------
// fdtp_classify
// classifies one word against the parser state and forms the next state
// ----------------------------------------------------------------------------
module fdtp_classify (
  input  logic [31:0]          word,
  input  logic                 restart,
  input  fdtp_pkg::fdtp_state_t  state,
  output fdtp_pkg::fdtp_state_t  state_next,
  output fdtp_pkg::fdtp_result_t result
);
  import fdtp_pkg::*;

  always_comb begin
    fdtp_state_t  cur;
    fdtp_state_t  nxt;
    fdtp_result_t res;
    logic [31:0]  swapped;

    cur     = restart ? STATE_RESET : state;
    nxt     = cur;
    res     = '0;
    res.kind = K_IGNORED;
    swapped = swap32(word);

    if (!cur.stopped) begin
      unique case (cur.phase)
        PH_NAME: begin
          res.kind        = K_NAME;
          res.value       = word;
          // first zero byte ends the name
          priority if (word[7:0] == 8'h00) begin
            res.valid_bytes = 3'd0;
            res.last_word   = 1'b1;
            nxt.phase       = PH_TOKEN;
          end else if (word[15:8] == 8'h00) begin
            res.valid_bytes = 3'd1;
            res.last_word   = 1'b1;
            nxt.phase       = PH_TOKEN;
          end else if (word[23:16] == 8'h00) begin
            res.valid_bytes = 3'd2;
            res.last_word   = 1'b1;
            nxt.phase       = PH_TOKEN;
          end else if (word[31:24] == 8'h00) begin
            res.valid_bytes = 3'd3;
            res.last_word   = 1'b1;
            nxt.phase       = PH_TOKEN;
          end else begin
            // no terminator yet, the name goes on
            res.valid_bytes = 3'd4;
          end
        end
        PH_PLEN: begin
          res.kind       = K_PLEN;
          res.value      = swapped;
          nxt.bytes_left = swapped;
          nxt.phase      = PH_POFF;
        end
        PH_POFF: begin
          res.kind  = K_POFF;
          res.value = swapped;
          nxt.phase = (cur.bytes_left == 32'd0) ? PH_TOKEN : PH_DATA;
        end
        PH_DATA: begin
          res.kind  = K_DATA;
          res.value = word;
          if (cur.bytes_left <= 32'd4) begin
            res.valid_bytes = cur.bytes_left[2:0];
            res.last_word   = 1'b1;
            nxt.bytes_left  = '0;
            nxt.phase       = PH_TOKEN;
          end else begin
            res.valid_bytes = 3'd4;
            nxt.bytes_left  = cur.bytes_left - 32'd4;
          end
        end
        default: begin
          // token phase, unused phase codes read as token phase
          res.value = swapped;
          nxt.phase = PH_TOKEN;
          unique case (swapped)
            TOK_BEGIN_NODE: begin
              if (cur.nest_depth >= DEPTH_LIMIT) begin
                res.kind    = K_DEPTHERR;
                nxt.stopped = 1'b1;
              end else begin
                res.kind       = K_BEGIN;
                nxt.nest_depth = cur.nest_depth + 7'd1;
                nxt.phase      = PH_NAME;
              end
            end
            TOK_END_NODE: begin
              if (cur.nest_depth == '0) begin
                res.kind    = K_DEPTHERR;
                nxt.stopped = 1'b1;
              end else begin
                res.kind       = K_ENDNODE;
                nxt.nest_depth = cur.nest_depth - 7'd1;
              end
            end
            TOK_PROP: begin
              res.kind  = K_PLEN;
              nxt.phase = PH_PLEN;
            end
            TOK_NOP: res.kind = K_NOP;
            TOK_END: begin
              res.kind    = K_END;
              nxt.stopped = 1'b1;
            end
            default: begin
              res.kind    = K_BAD;
              nxt.stopped = 1'b1;
            end
          endcase
        end
      endcase
    end

    res.depth  = nxt.nest_depth;
    state_next = nxt;
    result     = res;
  end

endmodule

// ===== rtl/fdt_structure_token_parser.sv =====
// ----------------------------------------------------------------------------
// fdt_structure_token_parser
// classifies device-tree structure block words into tokens, names and data
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after its word transaction
// throughput: one word per cycle, set by the single result register; a word is
//   taken whenever that register is empty or being drained in the same cycle
// reset: rst clears the parse state (token expected, depth zero, running)
//   and empties the result register
`include "assert_macros.svh"

module fdt_structure_token_parser (
  input  logic        clk,
  input  logic        rst,
  fdtp_in_if.sink     words,
  fdtp_out_if.source  results
);
  import fdtp_pkg::*;

  // parse state, updated on every accepted word
  fdtp_state_t  state;
  fdtp_state_t  state_next;

  // result register
  fdtp_result_t result;
  fdtp_result_t result_next;
  logic         result_valid;

  logic         accept;

  // the result register parts the two sides: a word goes in while the
  // previous result leaves in the same cycle
  assign words.ready = ~result_valid | results.ready;
  assign accept      = words.valid & words.ready;

  // all per-word work is in the classifier, between state and result
  fdtp_classify u_classify (
    .word       (words.word),
    .restart    (words.restart),
    .state      (state),
    .state_next (state_next),
    .result     (result_next)
  );

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (results.ready) begin
      result_valid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign results.valid       = result_valid;
  assign results.kind        = result.kind;
  assign results.depth       = result.depth;
  assign results.value       = result.value;
  assign results.last_word   = result.last_word;
  assign results.valid_bytes = result.valid_bytes;

  // depth never passes the ceiling
  `ASSERT_ALWAYS(a_depth_bound, state.nest_depth <= DEPTH_LIMIT)
  // a stalled result blocks new words
  `ASSERT_IMPLIES(a_stall_blocks, results.valid && !results.ready, !words.ready)
  // a begin-node transaction moves the parser into the name phase
  `ASSERT_NEXT(a_begin_to_name, accept && result_next.kind == K_BEGIN,
               state.phase == PH_NAME)
  // only end, bad token or depth error can stop a running parse
  `ASSERT_IMPLIES(a_stop_cause,
                  accept && state_next.stopped && !(state.stopped && !words.restart),
                  result_next.kind == K_END || result_next.kind == K_BAD ||
                  result_next.kind == K_DEPTHERR)

endmodule
